// File: rtl/fste_pkg.sv
// Shared types, character codes and sizing helpers of the format string text emitter.
package fste_pkg;

    localparam int ARG_WIDTH_DEF = 32;

    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_C          = 8'h63;
    localparam logic [7:0] CH_D          = 8'h64;
    localparam logic [7:0] CH_U          = 8'h75;
    localparam logic [7:0] CH_X          = 8'h78;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd87;

    // Commands from the sequencer to the digit shifter.
    typedef enum logic [2:0] {
        DOP_NOP,
        DOP_LOAD_DEC,
        DOP_LOAD_HEX,
        DOP_DABBLE,
        DOP_SHIFT
    } t_dig_op;

    // Decimal digits needed for a w-bit unsigned value: floor(w * log10(2)) + 1.
    function automatic int dec_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

    function automatic int hex_digits(input int w);
        return (w + 3) / 4;
    endfunction

    // Width of the digit shifter, in digits, large enough for either radix.
    function automatic int shifter_digits(input int w);
        return (dec_digits(w) > hex_digits(w)) ? dec_digits(w) : hex_digits(w);
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end
        return HEX_ALPHA_OFS + {4'd0, d};
    endfunction

endpackage

// File: rtl/format_string_text_emitter.sv
// Top level of the format string text emitter: input decode, sequencer and output register.
// Timing: a plain byte, %%, %c or an unknown selector enters the output register at the edge
// that takes its beat. %d and %u load there, take ARG_WIDTH dabble steps, skip leading zeros
// and send one digit at a time, holding while the output register is full (%x has no dabble
// steps); the next beat is taken only after the last digit is registered. One beat is in work
// at a time. Reset (synchronous, i_rst_n low) clears the pending '%'.
module format_string_text_emitter #(
    parameter int ARG_WIDTH = fste_pkg::ARG_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Slave tdata, from bit 0 up: fmt_char[7:0], arg_word[ARG_WIDTH-1:0], zero fill.
    input  logic [((ARG_WIDTH + 15) / 8) * 8-1:0] i_s_tdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // Master tdata, from bit 0 up: out_char[7:0]. tlast carries run_last.
    output logic [7:0]                           o_m_tdata,
    output logic                                 o_m_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready
);
    import fste_pkg::*;

    localparam int DW = shifter_digits(ARG_WIDTH);
    localparam int HD = hex_digits(ARG_WIDTH);
    localparam int CW = $clog2(ARG_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic                  r_pend;
    logic [CW-1:0]         r_cnt;
    logic [7:0]            r_out_char;
    logic                  r_out_last;
    logic                  r_out_valid;

    logic [7:0]            w_ch;
    logic [ARG_WIDTH-1:0]  w_arg;
    logic                  w_neg;
    logic [ARG_WIDTH-1:0]  w_value;
    logic                  w_out_free;
    logic                  w_in_acc;
    logic                  w_out_load;
    t_dig_op               w_op;
    logic [3:0]            w_top;

    assign w_ch    = i_s_tdata[7:0];
    assign w_arg   = i_s_tdata[8 +: ARG_WIDTH];
    assign w_neg   = (w_ch == CH_D) && w_arg[ARG_WIDTH-1];
    // The most negative value negates to itself, which read unsigned is its magnitude.
    assign w_value = w_neg ? (ARG_WIDTH'(0) - w_arg) : w_arg;

    // The output register can take a byte when empty or when its byte leaves this cycle.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // A new byte enters the output register this cycle.
    always_comb begin
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!r_pend) begin
                        w_out_load = (w_ch != CH_PERCENT);
                    end else if ((w_ch == CH_D) || (w_ch == CH_U) || (w_ch == CH_X)) begin
                        w_out_load = w_neg;
                    end else begin
                        w_out_load = 1'b1;
                    end
                end
            end
            S_EMIT:  w_out_load = w_out_free;
            default: w_out_load = 1'b0;
        endcase
    end

    // Commands to the digit shifter follow the sequencer state.
    always_comb begin
        w_op = DOP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && r_pend) begin
                    if ((w_ch == CH_D) || (w_ch == CH_U)) begin
                        w_op = DOP_LOAD_DEC;
                    end else if (w_ch == CH_X) begin
                        w_op = DOP_LOAD_HEX;
                    end
                end
            end
            S_CONV: w_op = DOP_DABBLE;
            S_SKIP: begin
                if ((w_top == 4'd0) && (r_cnt > CW'(1))) begin
                    w_op = DOP_SHIFT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_op = DOP_SHIFT;
                end
            end
            default: w_op = DOP_NOP;
        endcase
    end

    fste_digits #(
        .ARG_WIDTH(ARG_WIDTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_op    (w_op),
        .i_value (w_value),
        .o_top   (w_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_m_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (!r_pend) begin
                            if (w_ch == CH_PERCENT) begin
                                r_pend <= 1'b1;
                            end else begin
                                r_out_char  <= w_ch;
                                r_out_last  <= 1'b1;
                                r_out_valid <= 1'b1;
                            end
                        end else begin
                            r_pend <= 1'b0;
                            unique case (w_ch) inside
                                CH_PERCENT: begin
                                    r_out_char  <= CH_PERCENT;
                                    r_out_last  <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end
                                CH_C: begin
                                    r_out_char  <= w_arg[7:0];
                                    r_out_last  <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end
                                CH_D, CH_U: begin
                                    // A negative signed value sends its sign first.
                                    if (w_neg) begin
                                        r_out_char  <= CH_MINUS;
                                        r_out_last  <= 1'b0;
                                        r_out_valid <= 1'b1;
                                    end
                                    r_cnt   <= CW'(ARG_WIDTH);
                                    r_state <= S_CONV;
                                end
                                CH_X: begin
                                    r_cnt   <= CW'(HD);
                                    r_state <= S_SKIP;
                                end
                                default: begin
                                    // Unknown selector: the '%' is dropped, the byte copied.
                                    r_out_char  <= w_ch;
                                    r_out_last  <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_CONV: begin
                    if (r_cnt == CW'(1)) begin
                        r_cnt   <= CW'(DW);
                        r_state <= S_SKIP;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                S_SKIP: begin
                    // Leading zeros are dropped, but the units digit always stays.
                    if ((w_top == 4'd0) && (r_cnt > CW'(1))) begin
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_char  <= digit_char(w_top);
                        r_out_last  <= (r_cnt == CW'(1));
                        r_out_valid <= 1'b1;
                        r_cnt       <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;
    assign o_m_tvalid = r_out_valid;

`ifndef SYNTH
    // A byte that is not the last of its run means the sequencer still has digits to send.
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (r_state != S_IDLE))
        else $error("non-final output byte while the sequencer is idle");

    // Skipping and sending digits never runs the digit count down to zero.
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SKIP) || (r_state == S_EMIT)) |-> (r_cnt != '0))
        else $error("digit count empty while digits are pending");

    // The last conversion step hands the full decimal digit count to the skip stage.
    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CONV) && (r_cnt == CW'(1))) |=>
        ((r_state == S_SKIP) && (r_cnt == CW'(DW))))
        else $error("conversion did not end in the skip stage");
`endif

endmodule

// File: rtl/fste_digits.sv
// Bit-serial binary to BCD converter and digit shift register.
module fste_digits #(
    parameter int ARG_WIDTH = fste_pkg::ARG_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  fste_pkg::t_dig_op    i_op,
    input  logic [ARG_WIDTH-1:0] i_value,
    output logic [3:0]           o_top
);
    import fste_pkg::*;

    localparam int DW  = shifter_digits(ARG_WIDTH);
    localparam int HD  = hex_digits(ARG_WIDTH);
    localparam int DWB = DW * 4;

    logic [ARG_WIDTH-1:0] r_bin;
    logic [DWB-1:0]       r_dig;
    logic [DWB-1:0]       w_adj;

    // Each BCD digit of five or more gets three added before the next shift.
    always_comb begin
        for (int k = 0; k < DW; k++) begin
            if (r_dig[k*4 +: 4] >= 4'd5) begin
                w_adj[k*4 +: 4] = r_dig[k*4 +: 4] + 4'd3;
            end else begin
                w_adj[k*4 +: 4] = r_dig[k*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DOP_LOAD_DEC: begin
                r_bin <= i_value;
                r_dig <= '0;
            end
            DOP_LOAD_HEX: begin
                // Hex digits are placed at the top so that they leave first.
                r_dig <= DWB'(i_value) << ((DW - HD) * 4);
            end
            DOP_DABBLE: begin
                r_dig <= {w_adj[DWB-2:0], r_bin[ARG_WIDTH-1]};
                r_bin <= {r_bin[ARG_WIDTH-2:0], 1'b0};
            end
            DOP_SHIFT: begin
                r_dig <= {r_dig[DWB-5:0], 4'd0};
            end
            default: begin
            end
        endcase
    end

    assign o_top = r_dig[DWB-1 -: 4];

endmodule
